[rtl/dmtq_pkg.sv]
// shared types and constants for the destination-matched transmit queue
`default_nettype none

package dmtq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int HANDLE_BITS = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [15:0] BCAST_DEST = 16'hFFFF;

	// event kinds carried in the low bits of s_tuser
	typedef enum logic [1:0] {
		MODE_ENQUEUE     = 2'd0,
		MODE_DATA_REQ    = 2'd1,
		MODE_QUEUE_CHECK = 2'd2,
		MODE_TX_DONE     = 2'd3
	} mode_t;

	// one queue slot
	typedef struct packed {
		logic [HANDLE_BITS-1:0] handle;
		logic [15:0]            dst;
	} entry_t;

endpackage

`default_nettype wire

[rtl/dest_matched_tx_queue_unit.sv]
// destination-matched mac transmit queue with a serial scan/compaction walker
// a broadcast enqueue is sent at once from the tail; any other send or removal walks the store at one entry
//   per cycle through the single read port
// transmit done runs compaction, then retry, then the destination scan, then the fallback to the head
// throughput: one transaction at a time, s_tready is low until the result is loaded
// reset: arst_n clears count, in-flight mark, radio busy, last destination and ack bit;
//   store contents are undefined until written and never read beyond the count
`default_nettype none

module dest_matched_tx_queue_unit
	import dmtq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input transaction
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // dst_addr[15:0], pkt_handle[31:16], channel_clear[32]
	input  wire logic [2:0]  s_tuser,  // mode[1:0], is_broadcast[2]
	// result transaction
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata   // accepted[0], send_valid[1], send_handle[17:2],
	                                   // send_dst[33:18], freed_valid[34],
	                                   // freed_handle[50:35], queue_count[57:51],
	                                   // ack_pending[58]
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_WALK,
		ST_RETRY,
		ST_FINISH
	} state_t;

	// what the walker does with each entry it reads
	typedef enum logic [1:0] {
		WALK_FIRST,
		WALK_MATCH,
		WALK_COMPACT
	} walk_t;

	state_t state_q;
	walk_t  walk_kind_q;

	// latched event
	mode_t                  mode_q;
	logic                   bcast_q;
	logic [15:0]            dst_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic                   clear_q;

	// queue state
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] inflight_q;
	logic             inflight_vld_q;
	logic             busy_q;
	logic [15:0]      last_dest_q;
	logic             ack_q;

	// walker
	logic [CNT_W-1:0] ptr_q;
	logic [15:0]      target_q;
	logic             fallback_q;
	logic             first_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	entry_t           rd_data_s1;

	// result fields
	logic        accepted_q;
	logic        send_valid_q;
	logic [15:0] send_handle_q;
	logic [15:0] send_dst_q;
	logic        freed_valid_q;
	logic [15:0] freed_handle_q;
	logic        m_tvalid_q;
	logic [63:0] m_tdata_q;

	// entry store
	entry_t           mem [QUEUE_DEPTH];
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;

	logic walk_issue;
	logic walk_hit;
	logic walk_end;
	logic enq_ok;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// the walker issues one read per cycle and judges it in the next cycle
	assign walk_issue = (ptr_q < count_q);
	assign walk_hit   = rd_vld_s1 && ((walk_kind_q == WALK_FIRST) ||
		((walk_kind_q == WALK_MATCH) && (rd_data_s1.dst == target_q)));
	assign walk_end   = !rd_vld_s1 && !walk_issue;

	// room left, and a broadcast needs the radio free
	assign enq_ok = (count_q < CNT_W'(QUEUE_DEPTH)) && !(bcast_q && busy_q);

	// store write port: tail append, or closing the gap one slot down
	always_comb begin
		mem_we           = 1'b0;
		mem_waddr        = count_q[IDX_W-1:0];
		mem_wdata.handle = handle_q;
		mem_wdata.dst    = dst_q;
		if (state_q == ST_DECIDE && mode_q == MODE_ENQUEUE && enq_ok) begin
			mem_we = 1'b1;
		end else if (state_q == ST_WALK && walk_kind_q == WALK_COMPACT &&
			rd_vld_s1 && !first_q) begin
			mem_we    = 1'b1;
			mem_waddr = rd_idx_s1 - IDX_W'(1);
			mem_wdata = rd_data_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= mem[ptr_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			walk_kind_q    <= WALK_FIRST;
			mode_q         <= MODE_ENQUEUE;
			bcast_q        <= 1'b0;
			dst_q          <= '0;
			handle_q       <= '0;
			clear_q        <= 1'b0;
			count_q        <= '0;
			inflight_q     <= '0;
			inflight_vld_q <= 1'b0;
			busy_q         <= 1'b0;
			last_dest_q    <= '0;
			ack_q          <= 1'b0;
			ptr_q          <= '0;
			target_q       <= '0;
			fallback_q     <= 1'b0;
			first_q        <= 1'b0;
			rd_vld_s1      <= 1'b0;
			rd_idx_s1      <= '0;
			accepted_q     <= 1'b0;
			send_valid_q   <= 1'b0;
			send_handle_q  <= '0;
			send_dst_q     <= '0;
			freed_valid_q  <= 1'b0;
			freed_handle_q <= '0;
			m_tvalid_q     <= 1'b0;
			m_tdata_q      <= '0;
		end else begin
			// the finish state drives the result register itself
			if (m_tvalid_q && m_tready && state_q != ST_FINISH) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						mode_q         <= mode_t'(s_tuser[1:0]);
						bcast_q        <= s_tuser[2];
						dst_q          <= s_tdata[15:0];
						handle_q       <= HANDLE_BITS'(s_tdata[31:16]);
						clear_q        <= s_tdata[32];
						accepted_q     <= 1'b0;
						send_valid_q   <= 1'b0;
						send_handle_q  <= '0;
						send_dst_q     <= '0;
						freed_valid_q  <= 1'b0;
						freed_handle_q <= '0;
						state_q        <= ST_DECIDE;
					end
				end

				ST_DECIDE: begin
					ptr_q      <= '0;
					rd_vld_s1  <= 1'b0;
					fallback_q <= 1'b0;
					state_q    <= ST_FINISH;
					unique case (mode_q)
						MODE_ENQUEUE: begin
							if (enq_ok) begin
								count_q    <= count_q + CNT_W'(1);
								accepted_q <= 1'b1;
								ack_q      <= 1'b1;
								if (bcast_q) begin
									// sent at once from the tail, last_dest untouched
									inflight_q     <= count_q[IDX_W-1:0];
									inflight_vld_q <= 1'b1;
									busy_q         <= 1'b1;
									send_valid_q   <= 1'b1;
									send_handle_q  <= 16'(handle_q);
									send_dst_q     <= dst_q;
								end else if (!busy_q && clear_q) begin
									walk_kind_q <= WALK_FIRST;
									state_q     <= ST_WALK;
								end
							end
						end
						MODE_DATA_REQ: begin
							if (count_q != '0 && !busy_q) begin
								walk_kind_q <= WALK_MATCH;
								target_q    <= dst_q;
								state_q     <= ST_WALK;
							end
						end
						MODE_QUEUE_CHECK: begin
							if (!busy_q && clear_q && count_q != '0) begin
								walk_kind_q <= WALK_FIRST;
								state_q     <= ST_WALK;
							end
						end
						MODE_TX_DONE: begin
							busy_q         <= 1'b0;
							inflight_vld_q <= 1'b0;
							if (inflight_vld_q && (CNT_W'(inflight_q) < count_q)) begin
								// read the sent slot, then shift the rest down
								walk_kind_q <= WALK_COMPACT;
								ptr_q       <= CNT_W'(inflight_q);
								first_q     <= 1'b1;
								state_q     <= ST_WALK;
							end else begin
								state_q <= ST_RETRY;
							end
						end
						default: begin
							state_q <= ST_FINISH;
						end
					endcase
				end

				ST_WALK: begin
					rd_vld_s1 <= walk_issue;
					rd_idx_s1 <= ptr_q[IDX_W-1:0];
					ptr_q     <= ptr_q + CNT_W'(walk_issue);
					if (walk_kind_q == WALK_COMPACT) begin
						if (rd_vld_s1 && first_q) begin
							first_q        <= 1'b0;
							freed_handle_q <= 16'(rd_data_s1.handle);
						end
						if (walk_end) begin
							count_q       <= count_q - CNT_W'(1);
							freed_valid_q <= 1'b1;
							state_q       <= ST_RETRY;
						end
					end else if (walk_hit) begin
						last_dest_q    <= rd_data_s1.dst;
						inflight_q     <= rd_idx_s1;
						inflight_vld_q <= 1'b1;
						busy_q         <= 1'b1;
						send_valid_q   <= 1'b1;
						send_handle_q  <= 16'(rd_data_s1.handle);
						send_dst_q     <= rd_data_s1.dst;
						rd_vld_s1      <= 1'b0;
						state_q        <= ST_FINISH;
					end else if (walk_end) begin
						if (fallback_q) begin
							// no entry for the same destination: take the head
							fallback_q  <= 1'b0;
							walk_kind_q <= WALK_FIRST;
							ptr_q       <= '0;
							rd_vld_s1   <= 1'b0;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end

				ST_RETRY: begin
					ptr_q     <= '0;
					rd_vld_s1 <= 1'b0;
					state_q   <= ST_FINISH;
					if (count_q != '0 && last_dest_q != BCAST_DEST && clear_q) begin
						walk_kind_q <= WALK_MATCH;
						target_q    <= last_dest_q;
						fallback_q  <= 1'b1;
						state_q     <= ST_WALK;
					end else if (count_q == '0) begin
						ack_q <= 1'b0;
					end
				end

				ST_FINISH: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {5'b0, ack_q, 7'(count_q), freed_handle_q,
							freed_valid_q, send_dst_q, send_handle_q, send_valid_q,
							accepted_q};
						state_q    <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_inflight_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_vld_q |-> (CNT_W'(inflight_q) < count_q))
		else $error("in-flight slot outside the held entries");

	a_busy_has_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> inflight_vld_q)
		else $error("radio busy with no entry in flight");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside finish state");

	a_accept_excludes_free: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> !(m_tdata_q[0] && m_tdata_q[34]))
		else $error("enqueue and removal in one transaction");
`endif

endmodule

`default_nettype wire
